// ===== src/hnm_pkg.sv =====
// shared types, constants and helpers for the height to normal map block
// no dependencies
package hnm_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 256;
    localparam int unsigned MAX_HEIGHT_DEF = 256;
    localparam int unsigned CRD_W          = 13;   // holds coordinates and dims up to 4096
    localparam int unsigned ADDR_W_MAX     = 24;   // 4096 * 4096 entries
    localparam int unsigned CFG_W          = 9;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned GRAD_W         = 11;   // +-1020
    localparam int unsigned SUMSQ_W        = 22;   // gx^2 + gy^2 + 255^2
    localparam int unsigned CFG_RESET      = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } t_reg_idx;

    typedef enum logic {
        FUNC_LOAD    = 1'b0,
        FUNC_COMPUTE = 1'b1
    } t_func;

    typedef struct packed {
        logic       func;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] height;
    } t_in_req;

    typedef struct packed {
        logic [7:0] nx_byte;
        logic [7:0] ny_byte;
        logic [7:0] nz_byte;
    } t_out_req;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [ADDR_W_MAX-1:0] addr;
        logic [7:0]            wdata;
    } t_mem_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_DRAIN,
        ST_SUM,
        ST_PACK,
        ST_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        PK_IDLE,
        PK_SQ,
        PK_SCALE,
        PK_TSQ,
        PK_TEST
    } t_pack_state;

    // sobel weights per neighbor, order: ul, u, ur, l, r, dl, d, dr
    function automatic logic signed [2:0] gx_weight(input logic [2:0] k);
        logic signed [2:0] w;
        unique case (k)
            3'd0, 3'd5: w = -3'sd1;
            3'd2, 3'd7: w = 3'sd1;
            3'd3:       w = -3'sd2;
            3'd4:       w = 3'sd2;
            default:    w = 3'sd0;
        endcase
        return w;
    endfunction

    function automatic logic signed [2:0] gy_weight(input logic [2:0] k);
        logic signed [2:0] w;
        unique case (k)
            3'd0, 3'd2: w = 3'sd1;
            3'd1:       w = 3'sd2;
            3'd5, 3'd7: w = -3'sd1;
            3'd6:       w = -3'sd2;
            default:    w = 3'sd0;
        endcase
        return w;
    endfunction

endpackage

// ===== src/hnm_store.sv =====
// height frame store, single port, registered read
// depends on hnm_pkg
module hnm_store #(
    parameter int unsigned MAX_WIDTH  = hnm_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = hnm_pkg::MAX_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  hnm_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);
    localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic [7:0]        r_mem [DEPTH];
    logic [ADDR_W-1:0] addr;

    assign addr = i_req.addr[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[addr];
        end
    end
endmodule

// ===== src/hnm_pack.sv =====
// iterative byte packer: finds floor(255*(1+v/sqrt(s))/2) per component, bit by bit
// depends on hnm_pkg
module hnm_pack (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [hnm_pkg::GRAD_W-1:0]     i_gx,
    input  logic signed [hnm_pkg::GRAD_W-1:0]     i_gy,
    input  logic        [hnm_pkg::SUMSQ_W-1:0]    i_s,
    output logic                                  o_done,
    output hnm_pkg::t_out_req                     o_res
);
    localparam int unsigned SUMSQ_W_L = hnm_pkg::SUMSQ_W;

    hnm_pkg::t_pack_state r_st, n_st;
    logic [1:0]  r_comp, n_comp;
    logic [2:0]  r_bi, n_bi;
    logic [7:0]  r_b, n_b;
    logic        r_done, n_done;

    logic signed [11:0] r_v;
    logic [19:0]        r_vv;
    logic [36:0]        r_rhs;
    logic [15:0]        r_tt;
    logic [SUMSQ_W_L-1:0] r_s;

    logic [7:0]         cand;
    logic signed [9:0]  t;
    logic [8:0]         tmag;
    logic [37:0]        lhs;
    logic               tpos;
    logic               vneg;
    logic               fit;
    logic signed [11:0] v_sel;

    function automatic logic [10:0] vmag_sel(input logic signed [11:0] v);
        return v[11] ? 11'(-v) : v[10:0];
    endfunction

    always_comb begin
        unique case (r_comp)
            2'd0:    v_sel = -{i_gx[hnm_pkg::GRAD_W-1], i_gx};
            2'd1:    v_sel = {i_gy[hnm_pkg::GRAD_W-1], i_gy};
            default: v_sel = 12'sd255;
        endcase
    end

    assign cand = r_b | (8'h80 >> r_bi);
    assign t    = $signed({1'b0, cand, 1'b0}) - 10'sd255;
    assign tmag = t[9] ? 9'(-t) : t[8:0];
    assign lhs  = 38'(r_tt) * 38'(r_s);
    assign tpos = cand[7];
    assign vneg = r_v[11];

    always_comb begin
        priority if (!tpos && !vneg) begin
            fit = 1'b1;
        end else if (tpos && vneg) begin
            fit = 1'b0;
        end else if (tpos) begin
            fit = lhs <= 38'(r_rhs);
        end else begin
            fit = lhs >= 38'(r_rhs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= hnm_pkg::PK_IDLE;
            r_comp <= '0;
            r_bi   <= '0;
            r_b    <= '0;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_comp <= n_comp;
            r_bi   <= n_bi;
            r_b    <= n_b;
            r_done <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_st == hnm_pkg::PK_SQ) begin
            r_s  <= i_s;
            r_v  <= v_sel;
            r_vv <= 20'(vmag_sel(v_sel)) * 20'(vmag_sel(v_sel));
        end
        if (r_st == hnm_pkg::PK_SCALE) begin
            r_rhs <= 37'(r_vv) * 37'd65025;
        end
        if (r_st == hnm_pkg::PK_TSQ) begin
            r_tt <= 16'(tmag) * 16'(tmag);
        end
        if (r_st == hnm_pkg::PK_TEST && r_bi == 3'd7) begin
            unique case (r_comp)
                2'd0:    o_res.nx_byte <= fit ? cand : r_b;
                2'd1:    o_res.ny_byte <= fit ? cand : r_b;
                default: o_res.nz_byte <= fit ? cand : r_b;
            endcase
        end
    end

    always_comb begin
        n_st   = r_st;
        n_comp = r_comp;
        n_bi   = r_bi;
        n_b    = r_b;
        n_done = 1'b0;
        unique case (r_st)
            hnm_pkg::PK_IDLE: begin
                if (i_start) begin
                    n_comp = '0;
                    n_st   = hnm_pkg::PK_SQ;
                end
            end
            hnm_pkg::PK_SQ: begin
                n_st = hnm_pkg::PK_SCALE;
            end
            hnm_pkg::PK_SCALE: begin
                n_b  = '0;
                n_bi = '0;
                n_st = hnm_pkg::PK_TSQ;
            end
            hnm_pkg::PK_TSQ: begin
                n_st = hnm_pkg::PK_TEST;
            end
            hnm_pkg::PK_TEST: begin
                if (fit) begin
                    n_b = cand;
                end
                if (r_bi == 3'd7) begin
                    if (r_comp == 2'd2) begin
                        n_done = 1'b1;
                        n_st   = hnm_pkg::PK_IDLE;
                    end else begin
                        n_comp = r_comp + 2'd1;
                        n_st   = hnm_pkg::PK_SQ;
                    end
                end else begin
                    n_bi = r_bi + 3'd1;
                    n_st = hnm_pkg::PK_TSQ;
                end
            end
            default: n_st = hnm_pkg::PK_IDLE;
        endcase
    end

    assign o_done = r_done;
endmodule

// ===== src/height_to_normal_map_sobel.sv =====
// top level of the height to normal map block: sequencer, gradient accumulation
// depends on hnm_pkg, hnm_store, hnm_pack
//
// usage
//   input channel (valid/ready) carries one request: func, col, row, height.
//   a load inside the image writes one height into the frame store; loads give no result.
//   a compute request reads the eight wrap-around neighbors of (col,row),
//   forms the sobel gradients and returns one request with three packed bytes.
//   config port: write enable, register index, 9-bit data; index 0 is
//   image_width, 1 is image_height; write only while the block is idle.
//   timing: a load writes the store from the LOAD state. a compute reads the
//   eight neighbors one after another through the single store port (READ),
//   waits for the last read data (DRAIN), forms the sum of squares (SUM) and
//   starts the packer, which per component squares and scales it (SQ, SCALE),
//   then tests one result bit at a time, squaring the candidate (TSQ), then
//   comparing (TEST); the packer's registered done flag moves the block to OUT.
//   one request is in flight at a time; ready is low while it is worked on.
//   reset clears control state and sets both dims to 256; the store is not
//   cleared and must be loaded before it is read.
//   a stalled receiver holds the result in the output register; the input
//   stays blocked until the result is taken.
module height_to_normal_map_sobel #(
    parameter int unsigned MAX_WIDTH  = hnm_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = hnm_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  hnm_pkg::t_in_req                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output hnm_pkg::t_out_req               o_out_data,
    input  logic                            i_cfg_we,
    input  logic [hnm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hnm_pkg::CFG_W-1:0]       i_cfg_data
);
    localparam int unsigned CW = hnm_pkg::CRD_W;
    localparam int unsigned AW = hnm_pkg::ADDR_W_MAX;
    localparam int unsigned GW = hnm_pkg::GRAD_W;

    // config registers
    logic [hnm_pkg::CFG_W-1:0] r_cfg_w, r_cfg_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= hnm_pkg::CFG_W'(hnm_pkg::CFG_RESET);
            r_cfg_h <= hnm_pkg::CFG_W'(hnm_pkg::CFG_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == hnm_pkg::REG_IMAGE_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end
            if (i_cfg_idx == hnm_pkg::REG_IMAGE_HEIGHT) begin
                r_cfg_h <= i_cfg_data;
            end
        end
    end

    // effective dims, saturated to 1..MAX
    logic [CW-1:0] dim_w, dim_h;
    always_comb begin
        if (r_cfg_w == '0) begin
            dim_w = CW'(1);
        end else if (CW'(r_cfg_w) > CW'(MAX_WIDTH)) begin
            dim_w = CW'(MAX_WIDTH);
        end else begin
            dim_w = CW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            dim_h = CW'(1);
        end else if (CW'(r_cfg_h) > CW'(MAX_HEIGHT)) begin
            dim_h = CW'(MAX_HEIGHT);
        end else begin
            dim_h = CW'(r_cfg_h);
        end
    end

    // request coordinates: clamp for compute, plus wrap-around neighbors
    logic [CW-1:0] in_x, in_y, cx, cy;
    assign in_x = CW'(i_in_data.col);
    assign in_y = CW'(i_in_data.row);
    assign cx   = (in_x >= dim_w) ? dim_w - CW'(1) : in_x;
    assign cy   = (in_y >= dim_h) ? dim_h - CW'(1) : in_y;

    logic [CW-1:0] r_x, r_y, r_xl, r_xr, r_yu, r_yd;
    logic [7:0]    r_hv;
    logic          r_in_img;

    logic accept_in;
    assign accept_in = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_x      <= cx;
            r_y      <= cy;
            r_xl     <= (cx == '0) ? dim_w - CW'(1) : cx - CW'(1);
            r_xr     <= (cx + CW'(1) >= dim_w) ? '0 : cx + CW'(1);
            r_yu     <= (cy == '0) ? dim_h - CW'(1) : cy - CW'(1);
            r_yd     <= (cy + CW'(1) >= dim_h) ? '0 : cy + CW'(1);
            r_hv     <= i_in_data.height;
            r_in_img <= (in_x < dim_w) && (in_y < dim_h);
        end
    end

    // sequencer
    hnm_pkg::t_top_state r_st, n_st;
    logic [2:0] r_k, n_k;       // neighbor being read
    logic       r_dv;           // store data valid this cycle
    logic [2:0] r_dk;           // neighbor that the data belongs to
    logic       pack_start;
    logic       pack_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= hnm_pkg::ST_IDLE;
            r_k  <= '0;
            r_dv <= 1'b0;
        end else begin
            r_st <= n_st;
            r_k  <= n_k;
            r_dv <= (r_st == hnm_pkg::ST_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dk <= r_k;
    end

    always_comb begin
        n_st       = r_st;
        n_k        = r_k;
        pack_start = 1'b0;
        unique case (r_st)
            hnm_pkg::ST_IDLE: begin
                if (accept_in) begin
                    n_k = '0;
                    if (i_in_data.func == hnm_pkg::FUNC_LOAD) begin
                        n_st = hnm_pkg::ST_LOAD;
                    end else begin
                        n_st = hnm_pkg::ST_READ;
                    end
                end
            end
            hnm_pkg::ST_LOAD: begin
                n_st = hnm_pkg::ST_IDLE;
            end
            hnm_pkg::ST_READ: begin
                n_k = r_k + 3'd1;
                if (r_k == 3'd7) begin
                    n_st = hnm_pkg::ST_DRAIN;
                end
            end
            hnm_pkg::ST_DRAIN: begin
                n_st = hnm_pkg::ST_SUM;
            end
            hnm_pkg::ST_SUM: begin
                pack_start = 1'b1;
                n_st       = hnm_pkg::ST_PACK;
            end
            hnm_pkg::ST_PACK: begin
                if (pack_done) begin
                    n_st = hnm_pkg::ST_OUT;
                end
            end
            hnm_pkg::ST_OUT: begin
                if (i_out_ready) begin
                    n_st = hnm_pkg::ST_IDLE;
                end
            end
            default: n_st = hnm_pkg::ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_st == hnm_pkg::ST_IDLE);
    assign o_out_valid = (r_st == hnm_pkg::ST_OUT);

    // neighbor address: row-major, MAX_WIDTH entries per row
    logic [CW-1:0] nb_x, nb_y;
    always_comb begin
        unique case (r_k)
            3'd0, 3'd3, 3'd5: nb_x = r_xl;
            3'd2, 3'd4, 3'd7: nb_x = r_xr;
            default:          nb_x = r_x;
        endcase
        unique case (r_k)
            3'd0, 3'd1, 3'd2: nb_y = r_yu;
            3'd5, 3'd6, 3'd7: nb_y = r_yd;
            default:          nb_y = r_y;
        endcase
    end

    hnm_pkg::t_mem_req mem_req;
    logic [7:0]        mem_rdata;
    logic [CW-1:0]     ax, ay;

    assign ax            = (r_st == hnm_pkg::ST_LOAD) ? r_x : nb_x;
    assign ay            = (r_st == hnm_pkg::ST_LOAD) ? r_y : nb_y;
    assign mem_req.we    = (r_st == hnm_pkg::ST_LOAD) && r_in_img;
    assign mem_req.re    = (r_st == hnm_pkg::ST_READ);
    assign mem_req.addr  = AW'(ay) * AW'(MAX_WIDTH) + AW'(ax);
    assign mem_req.wdata = r_hv;

    hnm_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // gradient accumulation, one neighbor per cycle as data returns
    logic signed [GW-1:0] r_gx, r_gy;
    logic signed [GW-1:0] samp;
    assign samp = $signed({3'b000, mem_rdata});

    always_ff @(posedge i_clk) begin
        if (r_st == hnm_pkg::ST_READ && r_k == 3'd0) begin
            r_gx <= '0;
            r_gy <= '0;
        end else if (r_dv) begin
            r_gx <= r_gx + GW'(samp * GW'(hnm_pkg::gx_weight(r_dk)));
            r_gy <= r_gy + GW'(samp * GW'(hnm_pkg::gy_weight(r_dk)));
        end
    end

    // sum of squares plus 255^2, once the last neighbor has been added in
    logic [hnm_pkg::SUMSQ_W-1:0] r_s;
    logic [GW-1:0]               gx_mag, gy_mag;
    assign gx_mag = r_gx[GW-1] ? GW'(-r_gx) : r_gx;
    assign gy_mag = r_gy[GW-1] ? GW'(-r_gy) : r_gy;

    always_ff @(posedge i_clk) begin
        if (r_st == hnm_pkg::ST_SUM) begin
            r_s <= hnm_pkg::SUMSQ_W'(gx_mag) * hnm_pkg::SUMSQ_W'(gx_mag)
                 + hnm_pkg::SUMSQ_W'(gy_mag) * hnm_pkg::SUMSQ_W'(gy_mag)
                 + hnm_pkg::SUMSQ_W'(65025);
        end
    end

    hnm_pkg::t_out_req pack_res;

    hnm_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pack_start),
        .i_gx    (r_gx),
        .i_gy    (r_gy),
        .i_s     (r_s),
        .o_done  (pack_done),
        .o_res   (pack_res)
    );

    // output register, held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (pack_done) begin
            o_out_data <= pack_res;
        end
    end

    // checks
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result is pending");

    a_compute_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept_in && i_in_data.func == hnm_pkg::FUNC_COMPUTE) |=> !o_in_ready)
        else $error("compute request did not block the input");

    a_write_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (r_st == hnm_pkg::ST_LOAD))
        else $error("store written outside a load");

    a_done_in_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pack_done |-> (r_st == hnm_pkg::ST_PACK))
        else $error("packer finished with no compute in flight");
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// testbench for height_to_normal_map_sobel: random loads and normal computes checked
// against a predictor with its own frame store; depends on hnm_pkg and the block
module tb;
    localparam int unsigned MAXW = 256;
    localparam int unsigned MAXH = 256;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    hnm_pkg::t_in_req    i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    hnm_pkg::t_out_req   o_out_data;
    logic       i_cfg_we = 1'b0;
    logic [hnm_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [hnm_pkg::CFG_W-1:0]     i_cfg_data = '0;

    height_to_normal_map_sobel dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state: own copy of heights and dims
    logic [7:0] heights [MAXW*MAXH];
    int unsigned img_w = 256, img_h = 256;

    hnm_pkg::t_in_req  pending_reqs[$];    // requests waiting for the driver
    hnm_pkg::t_out_req expected_normals[$];
    int       n_errors = 0;
    int       n_normals = 0;
    int       n_loads = 0;
    bit       hold_off = 1'b0;    // long receiver stall in progress

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned m);
        if (v < 1) return 1;
        if (v > m) return m;
        return v;
    endfunction

    function automatic longint px(int unsigned x, int unsigned y);
        return longint'(heights[y*MAXW + x]);
    endfunction

    // largest byte b with (2b-255)*sqrt(s) <= 255*v, by squared comparison
    function automatic logic [7:0] pack_byte(longint v, longint s);
        longint b, t, cand, lhs, rhs;
        bit ok;
        b = 0;
        for (int bit_w = 128; bit_w > 0; bit_w >>= 1) begin
            cand = b | bit_w;
            t = 2*cand - 255;
            lhs = t*t*s;
            rhs = 65025*v*v;
            if (t <= 0 && v >= 0) ok = 1;
            else if (t > 0 && v < 0) ok = 0;
            else if (t > 0) ok = (lhs <= rhs);
            else ok = (lhs >= rhs);
            if (ok) b = cand;
        end
        return b[7:0];
    endfunction

    // apply one accepted request to the predictor
    task automatic predict_normal(input hnm_pkg::t_in_req r);
        int unsigned w, h, x, y, xl, xr, yu, yd;
        longint gx, gy, s;
        hnm_pkg::t_out_req o;
        w = clamp_dim(img_w, MAXW);
        h = clamp_dim(img_h, MAXH);
        x = r.col;
        y = r.row;
        if (hnm_pkg::t_func'(r.func) == hnm_pkg::FUNC_LOAD) begin
            if (x < w && y < h) heights[y*MAXW + x] = r.height;
            return;
        end
        if (x >= w) x = w - 1;
        if (y >= h) y = h - 1;
        xl = (x == 0) ? w - 1 : x - 1;
        xr = (x + 1 >= w) ? 0 : x + 1;
        yu = (y == 0) ? h - 1 : y - 1;
        yd = (y + 1 >= h) ? 0 : y + 1;
        gy = px(xl,yu) + 2*px(x,yu) + px(xr,yu) - px(xl,yd) - 2*px(x,yd) - px(xr,yd);
        gx = px(xr,yu) + 2*px(xr,y) + px(xr,yd) - px(xl,yu) - 2*px(xl,y) - px(xl,yd);
        s = gx*gx + gy*gy + 65025;
        o.nx_byte = pack_byte(-gx, s);
        o.ny_byte = pack_byte(gy, s);
        o.nz_byte = pack_byte(255, s);
        expected_normals.push_back(o);
    endtask

    // driver: random gap before each request, holds valid until accepted
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_normal(i_in_data);
                drv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
                if (drv_gap == 0 && pending_reqs.size() != 0) begin
                    i_in_data <= pending_reqs.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid) begin
                if (drv_gap > 0) drv_gap--;
                else if (pending_reqs.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_reqs.pop_front();
                end
            end
        end
    end

    // monitor: checks each accepted result and draws the next stall
    int rcv_gap = 0;
    always @(posedge i_clk) begin
        hnm_pkg::t_out_req e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_normals.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_out_data);
                    n_errors++;
                end else begin
                    e = expected_normals.pop_front();
                    if (e.nx_byte !== o_out_data.nx_byte)
                        $display("%0t: nx expected %0d actual %0d", $time, e.nx_byte,
                                 o_out_data.nx_byte);
                    if (e.ny_byte !== o_out_data.ny_byte)
                        $display("%0t: ny expected %0d actual %0d", $time, e.ny_byte,
                                 o_out_data.ny_byte);
                    if (e.nz_byte !== o_out_data.nz_byte)
                        $display("%0t: nz expected %0d actual %0d", $time, e.nz_byte,
                                 o_out_data.nz_byte);
                    if (e !== o_out_data) n_errors++;
                end
                n_normals++;
                rcv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
                i_out_ready <= (rcv_gap == 0) && !hold_off;
            end else if (hold_off) begin
                i_out_ready <= 1'b0;
            end else if (rcv_gap > 0) begin
                rcv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // long stall on the receive side while requests keep coming
    initial begin
        wait (n_normals >= 40);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic write_reg(input hnm_pkg::t_reg_idx idx, input int unsigned v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v[hnm_pkg::CFG_W-1:0];
        if (idx == hnm_pkg::REG_IMAGE_WIDTH) img_w = v[hnm_pkg::CFG_W-1:0];
        else img_h = v[hnm_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic hnm_pkg::t_in_req mk_req(hnm_pkg::t_func f, int unsigned c,
                                                int unsigned r, int unsigned hgt);
        hnm_pkg::t_in_req q;
        q.func = f;
        q.col = c[7:0];
        q.row = r[7:0];
        q.height = hgt[7:0];
        return q;
    endfunction

    // loads the whole active image so every read is defined
    task automatic fill_image(input int unsigned w, input int unsigned h, input int mode);
        int unsigned v;
        for (int unsigned y = 0; y < h; y++)
            for (int unsigned x = 0; x < w; x++) begin
                case (mode)
                    0: v = 0;
                    1: v = 255;
                    2: v = ((x + y) % 2) ? 255 : 0;
                    default: v = $urandom_range(0, 255);
                endcase
                pending_reqs.push_back(mk_req(hnm_pkg::FUNC_LOAD, x, y, v));
                n_loads++;
            end
    endtask

    // waits until the block has nothing in flight, then a bit more
    task automatic drain();
        while (pending_reqs.size() != 0 || i_in_valid || expected_normals.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // one phase: set dims, fill, a mix of directed and random requests
    task automatic run_phase(input int unsigned w, input int unsigned h, input int mode,
                             input int unsigned n_rand);
        int unsigned fw, fh;
        write_reg(hnm_pkg::REG_IMAGE_WIDTH, w);
        write_reg(hnm_pkg::REG_IMAGE_HEIGHT, h);
        fw = clamp_dim(w, MAXW);
        fh = clamp_dim(h, MAXH);
        fill_image(fw, fh, mode);
        // corners, plus coordinates beyond the image that saturate
        pending_reqs.push_back(mk_req(hnm_pkg::FUNC_COMPUTE, 0, 0, 8'hAA));
        pending_reqs.push_back(mk_req(hnm_pkg::FUNC_COMPUTE, fw-1, fh-1, 8'h55));
        pending_reqs.push_back(mk_req(hnm_pkg::FUNC_COMPUTE, 255, 255, 8'hFF));
        for (int unsigned i = 0; i < n_rand; i++) begin
            // loads anywhere, including outside the image where they are ignored
            if ($urandom_range(0, 2) == 0) begin
                pending_reqs.push_back(mk_req(hnm_pkg::FUNC_LOAD, $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255)));
                n_loads++;
            end else if ($urandom_range(0, 9) == 0) begin
                pending_reqs.push_back(mk_req(hnm_pkg::FUNC_COMPUTE, $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255)));
            end else begin
                pending_reqs.push_back(mk_req(hnm_pkg::FUNC_COMPUTE, $urandom_range(0, fw-1),
                    $urandom_range(0, fh-1), $urandom_range(0, 255)));
            end
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // tiny images with coinciding neighbors and flat, checkerboard or random fields
        run_phase(1, 1, 1, 10);
        run_phase(2, 2, 2, 20);
        run_phase(0, 3, 3, 40);     // zero width counts as one
        run_phase(3, 1, 2, 40);
        run_phase(4, 5, 0, 40);
        // oversized values saturate to the maximum
        run_phase(511, 1, 3, 60);
        run_phase(1, 300, 2, 60);
        run_phase(7, 9, 3, 300);
        run_phase(16, 12, 3, 300);
        run_phase(5, 6, 3, 100);
        run_phase(3, 4, 2, 60);
        $display("covered %0d normals and %0d loads over eleven image sizes",
                 n_normals, n_loads);
        $display("including tiny, zero, maximum and oversized dimensions");
        if (n_errors == 0 && expected_normals.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
src/hnm_pkg.sv
src/hnm_store.sv
src/hnm_pack.sv
src/height_to_normal_map_sobel.sv
tb/sv/tb.sv
